// File: sv/assert_macros.svh
// assertion macros shared by the oscillator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, muted while reset is high
`define MWO_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds through reset
`define MWO_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mwo_pkg.sv
// package with oscillator constants, types and the quarter-wave sine table
`default_nettype none

package mwo_pkg;

   localparam int PHASE_BITS     = 32;
   localparam int SAMPLE_BITS    = 16;
   localparam int SINE_ADDR_BITS = 8;
   localparam int AMP_BITS       = 15;
   localparam int WAVE_BITS      = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam int UNIT_BITS  = SAMPLE_BITS + 1;
   localparam int UNIT_SHIFT = SAMPLE_BITS - 1;
   localparam int PROD_BITS  = UNIT_BITS + AMP_BITS + 1;
   localparam int SINE_SIZE  = 1 << SINE_ADDR_BITS;

   localparam logic [UNIT_BITS-1:0] FULL_SCALE = UNIT_BITS'(1) << UNIT_SHIFT;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TUNING_WORD = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM    = CSR_INDEX_BITS'(2);

   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SAWTOOTH = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   // phase stage between the accumulator and the shaping logic
   typedef struct packed {
      logic                  valid;
      logic [PHASE_BITS-1:0] phase;
   } stage_type;

   typedef logic [SINE_SIZE-1:0][SAMPLE_BITS-1:0] sine_table_type;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // quarter sine at full scale, taylor series in q30 with truncation each step
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    t;
      logic [63:0]    s;
      logic [63:0]    scaled;
      for (int k = 0; k < SINE_SIZE; k++) begin
         x  = (64'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - ((x2 * Q30_ONE) >> 30) / 64'd110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         scaled = (s * 64'(FULL_SCALE) + (Q30_ONE >> 1)) >> 30;
         tbl[k] = scaled[SAMPLE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

// File: sv/multi_waveform_oscillator.sv
// top level of the multi-waveform dds oscillator
`default_nettype none
`include "assert_macros.svh"

// Multi-waveform direct digital synthesis oscillator. Every request beat asks
// for one sample; a set restart bit clears the 32-bit phase accumulator before
// that sample is formed, and after each sample the phase advances by the
// tuning word (frequency / sample rate * 2^32, wrapping). The waveform register
// picks sine (quarter-wave table of 256 entries, mirrored by quadrant), square,
// sawtooth or triangle; each is formed at unit scale in q1.15, multiplied by
// the q0.15 amplitude and rounded to nearest with ties toward plus infinity, so
// the sample stays within plus or minus amplitude. A zero tuning word or a zero
// amplitude returns sample 0 with the invalid bit set, and the phase still
// advances. Throughput is one sample per clock cycle while the response side
// does not stall. Each accepted request is held in the phase register, and table
// lookup, the 17x16 multiply and rounding lead from there into the response
// register, which presents the response beat. The response register and the
// phase register each take a new beat while the one ahead of them moves on, so
// while a response beat is stalled the block still takes one more request into
// the phase register before it stalls the request side. The user is to write
// registers through the csr port only while no request is in flight; the block
// itself does not enforce this.
module multi_waveform_oscillator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_restart,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mwo_pkg::SAMPLE_BITS-1:0]  rsp_sample,
   output logic                                    rsp_invalid,
   // register write port
   input  wire logic                               csr_write,
   input  wire logic [mwo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import mwo_pkg::*;

   // configuration registers
   logic [PHASE_BITS-1:0] tuning_word_ff;
   logic [AMP_BITS-1:0]   amplitude_ff;
   wave_type              waveform_ff;

   // handshake
   logic      req_accept;
   logic      out_free;
   logic      stage_free;
   stage_type stage;

   // shaping and scaling
   logic signed [UNIT_BITS-1:0] unit;
   logic signed [PROD_BITS-1:0] product;
   logic signed [PROD_BITS-1:0] rounded;
   logic                        bad_setting;

   // response register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_in;
   logic                          rsp_invalid_ff;
   logic                          rsp_invalid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_word_ff <= '0;
         amplitude_ff   <= '0;
         waveform_ff    <= WAVE_SINE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TUNING_WORD: tuning_word_ff <= csr_data[PHASE_BITS-1:0];
            CSR_AMPLITUDE:   amplitude_ff   <= csr_data[AMP_BITS-1:0];
            CSR_WAVEFORM:    waveform_ff    <= wave_type'(csr_data[WAVE_BITS-1:0]);
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // each stage takes a beat when empty or when the beat ahead moves on
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_free = !stage.valid || out_free;
   assign req_stall  = !stage_free;
   assign req_accept = req_valid && stage_free;

   mwo_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .load        (req_accept),
      .restart     (req_restart),
      .tuning_word (tuning_word_ff),
      .advance     (out_free),
      .stage       (stage)
   );

   mwo_wave u_wave (
      .phase    (stage.phase),
      .waveform (waveform_ff),
      .unit     (unit)
   );

   always_comb begin
      bad_setting = (tuning_word_ff == '0) || (amplitude_ff == '0);
      // unit times amplitude, then round half up and drop the q15 fraction
      product = PROD_BITS'(unit) * PROD_BITS'($signed({1'b0, amplitude_ff}));
      rounded = product + (PROD_BITS'(1) <<< (UNIT_SHIFT - 1));

      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_invalid_in = rsp_invalid_ff;
      if (out_free) begin
         rsp_valid_in   = stage.valid;
         rsp_sample_in  = bad_setting ? '0 : rounded[UNIT_SHIFT +: SAMPLE_BITS];
         rsp_invalid_in = bad_setting;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff  <= rsp_sample_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_invalid = rsp_invalid_ff;

   // a flagged beat carries a zero sample
   `MWO_ASSERT(a_invalid_zero, clock, reset,
      rsp_valid_ff && rsp_invalid_ff |-> rsp_sample_ff == '0, "invalid beat with nonzero sample")

   // sample magnitude never exceeds the programmed amplitude
   `MWO_ASSERT(a_within_amp, clock, reset,
      rsp_valid_ff && !rsp_invalid_ff |->
      rsp_sample_ff <= $signed({1'b0, amplitude_ff}) &&
      rsp_sample_ff >= -$signed({1'b0, amplitude_ff}), "sample beyond amplitude")

   // no response beat right after reset
   `MWO_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid_ff && !stage.valid, "beat present after reset")

endmodule

`default_nettype wire

// File: sv/mwo_phase.sv
// phase accumulator and the registered phase stage
`default_nettype none
`include "assert_macros.svh"

module mwo_phase (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire logic                           restart,
   input  wire logic [mwo_pkg::PHASE_BITS-1:0] tuning_word,
   input  wire logic                           advance,
   output mwo_pkg::stage_type                  stage
);
   import mwo_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_used;
   stage_type             stage_ff;
   stage_type             stage_in;

   always_comb begin
      phase_used = restart ? '0 : phase_ff;
      phase_in   = phase_ff;
      stage_in   = stage_ff;
      if (load) begin
         phase_in       = phase_used + tuning_word;
         stage_in.valid = 1'b1;
         stage_in.phase = phase_used;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.phase <= stage_in.phase;
   end

   assign stage = stage_ff;

   `MWO_ASSERT(a_restart_zero, clock, reset,
      load && restart |=> stage_ff.valid && stage_ff.phase == '0 &&
      phase_ff == $past(tuning_word), "restart beat did not start from phase zero")

endmodule

`default_nettype wire

// File: sv/mwo_wave.sv
// waveform shaping: unit value in q1.15 from phase and waveform select
`default_nettype none

module mwo_wave (
   input  wire logic [mwo_pkg::PHASE_BITS-1:0]  phase,
   input  mwo_pkg::wave_type                    waveform,
   output logic signed [mwo_pkg::UNIT_BITS-1:0] unit
);
   import mwo_pkg::*;

   logic [1:0]                    quad;
   logic [SINE_ADDR_BITS-1:0]     idx;
   logic [SINE_ADDR_BITS-1:0]     idx_mirror;
   logic [UNIT_BITS-1:0]          mag;
   logic signed [UNIT_BITS-1:0]   w;
   logic signed [UNIT_BITS-1:0]   w_abs;
   logic signed [UNIT_BITS:0]     tri_val;

   always_comb begin
      quad       = phase[PHASE_BITS-1 -: 2];
      idx        = phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
      idx_mirror = SINE_ADDR_BITS'(0) - idx;

      // mirrored quadrants read the table backwards, top end is full scale
      if (quad[0]) begin
         if (idx == '0) begin
            mag = FULL_SCALE;
         end else begin
            mag = {1'b0, SINE_TABLE[idx_mirror]};
         end
      end else begin
         mag = {1'b0, SINE_TABLE[idx]};
      end

      // top sample bits of the phase as a signed ramp
      w       = UNIT_BITS'($signed(phase[PHASE_BITS-1 -: SAMPLE_BITS]));
      w_abs   = w[UNIT_BITS-1] ? -w : w;
      tri_val = ($signed({w_abs, 1'b0})) - $signed({1'b0, FULL_SCALE});

      case (waveform)
         WAVE_SINE: begin
            unit = quad[1] ? -$signed(mag) : $signed(mag);
         end
         WAVE_SQUARE: begin
            if (!phase[PHASE_BITS-1] && phase != '0) begin
               unit = $signed(FULL_SCALE);
            end else begin
               unit = -$signed(FULL_SCALE);
            end
         end
         WAVE_SAWTOOTH: begin
            unit = w;
         end
         WAVE_TRIANGLE: begin
            unit = tri_val[UNIT_BITS-1:0];
         end
         default: begin
            unit = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: tb/sample_checker.sv
// checker: predicts each oscillator sample and compares it with the response beats
module sample_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic                               req_restart,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic signed [mwo_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input  wire logic                               rsp_invalid,
   input  wire logic                               csr_write,
   input  wire logic [mwo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int unsigned                             mismatches,
   output int unsigned                             pending,
   output int unsigned                             checked,
   output int unsigned                             flagged
);
   timeunit 1ns;
   timeprecision 1ps;
   import mwo_pkg::*;

   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned QUARTER_RAD = 64'd1686629713;
   localparam longint          UNIT_MAX    = 64'd1 << (SAMPLE_BITS - 1);
   localparam int              PRINT_LIMIT = 40;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          invalid;
   } sample_beat_type;

   sample_beat_type       expected_samples[$];
   longint                quarter_sine[SINE_SIZE];

   logic [PHASE_BITS-1:0] phase_acc;
   logic [PHASE_BITS-1:0] tuning;
   logic [AMP_BITS-1:0]   level;
   wave_type              shape;

   // quarter sine entry: taylor series in q30, truncated at every step
   function automatic longint sine_entry(int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned s;
      x    = (longint'(k) * QUARTER_RAD) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      for (int n = 5; n >= 1; n--)
         term = ONE_Q30 - ((x2 * term) >> 30) / longint'((2 * n) * (2 * n + 1));
      s = (x * term) >> 30;
      return longint'((s * UNIT_MAX + (ONE_Q30 >> 1)) >> 30);
   endfunction

   initial begin
      for (int k = 0; k < SINE_SIZE; k++)
         quarter_sine[k] = sine_entry(k);
   end

   function automatic sample_beat_type shape_sample(logic [PHASE_BITS-1:0] ph);
      sample_beat_type               beat;
      longint                        unit;
      longint                        magnitude;
      longint                        amp;
      longint                        scaled;
      int                            mirror;
      logic signed [SAMPLE_BITS-1:0] top;
      beat.sample  = '0;
      beat.invalid = 1'b0;
      amp          = longint'(level);
      unit         = 0;
      top          = ph[PHASE_BITS-1 -: SAMPLE_BITS];
      if (tuning == '0 || level == '0) begin
         beat.invalid = 1'b1;
         return beat;
      end
      if (shape == WAVE_SQUARE) begin
         // high only strictly inside the first half cycle
         scaled = (ph != '0 && !ph[PHASE_BITS-1]) ? amp : -amp;
      end else begin
         case (shape)
            WAVE_SINE: begin
               mirror = int'(ph[PHASE_BITS-3 -: SINE_ADDR_BITS]);
               if (ph[PHASE_BITS-2]) begin
                  mirror    = SINE_SIZE - mirror;
                  magnitude = (mirror == SINE_SIZE) ? UNIT_MAX : quarter_sine[mirror];
               end else begin
                  magnitude = quarter_sine[mirror];
               end
               unit = ph[PHASE_BITS-1] ? -magnitude : magnitude;
            end
            WAVE_SAWTOOTH: unit = longint'(top);
            default: begin
               magnitude = (top < 0) ? -longint'(top) : longint'(top);
               unit      = 2 * magnitude - UNIT_MAX;
            end
         endcase
         // round to nearest, ties toward plus infinity
         scaled = (unit * amp + (UNIT_MAX >>> 1)) >>> (SAMPLE_BITS - 1);
      end
      beat.sample = scaled[SAMPLE_BITS-1:0];
      return beat;
   endfunction

   task automatic report_mismatch(input string detail);
      if (mismatches < PRINT_LIMIT)
         $display("%0t ns mismatch: %s", $realtime, detail);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      sample_beat_type want;
      if (reset) begin
         phase_acc = '0;
         tuning    = '0;
         level     = '0;
         shape     = WAVE_SINE;
         expected_samples.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TUNING_WORD: tuning = csr_data[PHASE_BITS-1:0];
               CSR_AMPLITUDE:   level  = csr_data[AMP_BITS-1:0];
               CSR_WAVEFORM:    shape  = wave_type'(csr_data[WAVE_BITS-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("sample beat %0d / invalid %0b with none pending",
                                         rsp_sample, rsp_invalid));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample)
                  report_mismatch($sformatf("sample %0d, expected %0d (beat %0d)",
                                            rsp_sample, want.sample, checked));
               if (rsp_invalid !== want.invalid)
                  report_mismatch($sformatf("invalid %0b, expected %0b (beat %0d)",
                                            rsp_invalid, want.invalid, checked));
               checked++;
               if (want.invalid)
                  flagged++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_restart)
               phase_acc = '0;
            expected_samples.push_back(shape_sample(phase_acc));
            phase_acc = phase_acc + tuning;
         end
      end
      pending <= expected_samples.size();
   end

endmodule

// File: tb/tb.sv
// testbench top: clock, reset, stimulus, stall patterns and verdict for the oscillator
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mwo_pkg::*;

   // index with no register behind it, writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = CSR_INDEX_BITS'(3);
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int BLOCKS      = 19;
   localparam int BLOCK_BEATS = 100;
   localparam int IDLE_PCT    = 28;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_restart = 1'b0;
   logic                          rsp_stall   = 1'b0;
   logic                          csr_write   = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data    = '0;
   logic                          req_stall;
   logic                          rsp_valid;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;
   logic                          rsp_invalid;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned checked;
   int unsigned flagged;

   // stimulus bookkeeping for the summary
   int unsigned beats_sent    = 0;
   int unsigned restarts_sent = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles  = 0;

   // steady: neither side idles; hold_now asks the receiver for one long hold-off
   bit steady   = 1'b0;
   bit hold_now = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multi_waveform_oscillator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_invalid (rsp_invalid),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   sample_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_invalid (rsp_invalid),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .pending     (pending),
      .checked     (checked),
      .flagged     (flagged)
   );

   // watchdog: ends the run when no beat and no register write moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("nothing moved for %0d cycles, %0d samples still owed", QUIET_LIMIT, pending);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls, none in steady stretches, one long hold-off on request
   initial begin : drain_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_now && !hold_done) begin
            // counted here so the sender keeps offering and the pipe backs up
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // offer one request beat, idling at random first; returns just after the accepting edge
   task automatic send_request(input logic restart);
      while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
      if (restart)
         restarts_sent++;
   endtask

   // stop offering and wait until every owed sample has come back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // back-to-back register writes, the spare index last; only called while idle
   task automatic program_oscillator(input logic [31:0] tuning_word,
                                     input logic [31:0] level_word,
                                     input wave_type    wave);
      csr_write <= 1'b1;
      csr_index <= CSR_TUNING_WORD;
      csr_data  <= tuning_word;
      @(posedge clock);
      csr_index <= CSR_AMPLITUDE;
      csr_data  <= level_word;
      @(posedge clock);
      // junk above the two waveform bits must not matter
      csr_index <= CSR_WAVEFORM;
      csr_data  <= {30'($urandom()), wave};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_data  <= $urandom();
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // tuning word mix: zero, all ones, single bits, slow tones, full random
   function automatic logic [31:0] pick_tuning();
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'd1 << $urandom_range(31);
         3, 4:    return 32'($urandom_range(32'hFFFF, 1));
         default: return $urandom();
      endcase
   endfunction

   // amplitude mix with random junk above bit 14
   function automatic logic [31:0] pick_level();
      logic [AMP_BITS-1:0] amp;
      case ($urandom_range(9))
         0:       amp = '0;
         1:       amp = '1;
         2:       amp = AMP_BITS'(1);
         default: amp = AMP_BITS'($urandom_range(32767, 1));
      endcase
      return {17'($urandom()), amp};
   endfunction

   // quarter-cycle steps from phase zero: hits both quadrant bits and the half-cycle points
   task automatic quarter_steps();
      send_request(1'b1);
      repeat (3)
         send_request(1'b0);
   endtask

   initial begin : stimulus
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;
      drain_pipeline();

      // registers still at reset: every sample flagged invalid
      send_request(1'b0);
      send_request(1'b1);
      drain_pipeline();

      // each waveform at full amplitude through phase 0, 1/4, 1/2, 3/4
      program_oscillator(32'h4000_0000, 32'h0000_7FFF, WAVE_SINE);
      quarter_steps();
      drain_pipeline();
      program_oscillator(32'h4000_0000, 32'h0000_7FFF, WAVE_SQUARE);
      quarter_steps();
      drain_pipeline();
      program_oscillator(32'h4000_0000, 32'h0000_7FFF, WAVE_SAWTOOTH);
      quarter_steps();
      drain_pipeline();
      program_oscillator(32'h4000_0000, 32'h0000_7FFF, WAVE_TRIANGLE);
      quarter_steps();
      drain_pipeline();

      // largest tuning word wraps the accumulator, smallest amplitude
      program_oscillator(32'hFFFF_FFFF, 32'h0000_0001, WAVE_TRIANGLE);
      send_request(1'b1);
      send_request(1'b0);
      drain_pipeline();

      // zero amplitude with junk above it: invalid, phase keeps moving
      program_oscillator(32'h1234_5678, 32'hFFFF_8000, WAVE_SINE);
      send_request(1'b1);
      send_request(1'b0);
      drain_pipeline();

      // zero tuning word
      program_oscillator(32'd0, 32'hFFFF_FFFF, WAVE_SAWTOOTH);
      send_request(1'b0);
      drain_pipeline();

      // random settings, cycling through the waveforms; two steady blocks, one of them with a hold-off
      for (int blk = 0; blk < BLOCKS; blk++) begin
         steady = (blk == 4) || (blk == 11);
         program_oscillator(pick_tuning(), pick_level(), wave_type'(blk % 4));
         if (blk == 11)
            hold_now = 1'b1;
         repeat (BLOCK_BEATS)
            send_request($urandom_range(15) == 0);
         drain_pipeline();
      end
      steady = 1'b0;

      // idle on to catch any stray response beat
      repeat (8)
         @(posedge clock);

      $display("sent %0d request beats (%0d with restart) under %0d register settings",
               beats_sent, restarts_sent, settings_used);
      $display("checked %0d samples across all four waveforms, %0d flagged invalid",
               checked, flagged);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
